// File: hw/rtl/sc2a_pkg.sv
// Shared types, scancode constants and ASCII lookup tables for the scancode-to-ASCII key stack.
package sc2a_pkg;

    typedef enum logic [1:0] {
        ACT_SCAN       = 2'd0,
        ACT_POP        = 2'd1,
        ACT_ACTIVATE   = 2'd2,
        ACT_DEACTIVATE = 2'd3
    } sc2a_action_t;

    localparam logic [7:0] SC_LSHIFT_MAKE  = 8'h2A;
    localparam logic [7:0] SC_RSHIFT_MAKE  = 8'h36;
    localparam logic [7:0] SC_LSHIFT_BREAK = 8'hAA;
    localparam logic [7:0] SC_RSHIFT_BREAK = 8'hB6;
    localparam logic [7:0] SC_CAPS_MAKE    = 8'h3A;
    localparam logic [7:0] SC_BREAK_BIT    = 8'h80;
    localparam logic [6:0] CASE_OFFSET     = 7'd32;
    localparam logic [6:0] CHAR_LOWER_A    = 7'h61;
    localparam logic [6:0] CHAR_LOWER_Z    = 7'h7A;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;   // latch the incoming transaction
        logic execute;   // update flags and stack, issue the stack read
        logic load;      // move the result into the output register
    } sc2a_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic out_valid; // output register holds an untaken result
    } sc2a_status_t;

    function automatic logic [6:0] plain_rom(input logic [6:0] code);
        logic [6:0] ch;
        unique case (code)
            7'h01: ch = 7'h1B; 7'h02: ch = 7'h31; 7'h03: ch = 7'h32; 7'h04: ch = 7'h33;
            7'h05: ch = 7'h34; 7'h06: ch = 7'h35; 7'h07: ch = 7'h36; 7'h08: ch = 7'h37;
            7'h09: ch = 7'h38; 7'h0A: ch = 7'h39; 7'h0B: ch = 7'h30; 7'h0C: ch = 7'h2D;
            7'h0D: ch = 7'h3D; 7'h0E: ch = 7'h08; 7'h0F: ch = 7'h09;
            7'h10: ch = 7'h71; 7'h11: ch = 7'h77; 7'h12: ch = 7'h65; 7'h13: ch = 7'h72;
            7'h14: ch = 7'h74; 7'h15: ch = 7'h79; 7'h16: ch = 7'h75; 7'h17: ch = 7'h69;
            7'h18: ch = 7'h6F; 7'h19: ch = 7'h70; 7'h1A: ch = 7'h5B; 7'h1B: ch = 7'h5D;
            7'h1C: ch = 7'h0A; 7'h1E: ch = 7'h61; 7'h1F: ch = 7'h73;
            7'h20: ch = 7'h64; 7'h21: ch = 7'h66; 7'h22: ch = 7'h67; 7'h23: ch = 7'h68;
            7'h24: ch = 7'h6A; 7'h25: ch = 7'h6B; 7'h26: ch = 7'h6C; 7'h27: ch = 7'h3B;
            7'h28: ch = 7'h27; 7'h29: ch = 7'h60; 7'h2B: ch = 7'h5C;
            7'h2C: ch = 7'h7A; 7'h2D: ch = 7'h78; 7'h2E: ch = 7'h63; 7'h2F: ch = 7'h76;
            7'h30: ch = 7'h62; 7'h31: ch = 7'h6E; 7'h32: ch = 7'h6D; 7'h33: ch = 7'h2C;
            7'h34: ch = 7'h2E; 7'h35: ch = 7'h2F; 7'h37: ch = 7'h2A; 7'h39: ch = 7'h20;
            7'h4A: ch = 7'h2D; 7'h4E: ch = 7'h2B;
            default: ch = 7'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [6:0] shifted_rom(input logic [6:0] code);
        logic [6:0] ch;
        unique case (code)
            7'h01: ch = 7'h1B; 7'h02: ch = 7'h21; 7'h03: ch = 7'h40; 7'h04: ch = 7'h23;
            7'h05: ch = 7'h24; 7'h06: ch = 7'h25; 7'h07: ch = 7'h5E; 7'h08: ch = 7'h26;
            7'h09: ch = 7'h2A; 7'h0A: ch = 7'h28; 7'h0B: ch = 7'h29; 7'h0C: ch = 7'h5F;
            7'h0D: ch = 7'h2B; 7'h0E: ch = 7'h08; 7'h0F: ch = 7'h09;
            7'h10: ch = 7'h51; 7'h11: ch = 7'h57; 7'h12: ch = 7'h45; 7'h13: ch = 7'h52;
            7'h14: ch = 7'h54; 7'h15: ch = 7'h59; 7'h16: ch = 7'h55; 7'h17: ch = 7'h49;
            7'h18: ch = 7'h4F; 7'h19: ch = 7'h50; 7'h1A: ch = 7'h7B; 7'h1B: ch = 7'h7D;
            7'h1C: ch = 7'h0A; 7'h1E: ch = 7'h41; 7'h1F: ch = 7'h53;
            7'h20: ch = 7'h44; 7'h21: ch = 7'h46; 7'h22: ch = 7'h47; 7'h23: ch = 7'h48;
            7'h24: ch = 7'h4A; 7'h25: ch = 7'h4B; 7'h26: ch = 7'h4C; 7'h27: ch = 7'h3A;
            7'h28: ch = 7'h22; 7'h29: ch = 7'h7E; 7'h2B: ch = 7'h7C;
            7'h2C: ch = 7'h5A; 7'h2D: ch = 7'h58; 7'h2E: ch = 7'h43; 7'h2F: ch = 7'h56;
            7'h30: ch = 7'h42; 7'h31: ch = 7'h4E; 7'h32: ch = 7'h4D; 7'h33: ch = 7'h3C;
            7'h34: ch = 7'h3E; 7'h35: ch = 7'h3F; 7'h37: ch = 7'h2A; 7'h39: ch = 7'h20;
            7'h4A: ch = 7'h2D; 7'h4E: ch = 7'h2B;
            default: ch = 7'h00;
        endcase
        return ch;
    endfunction

endpackage

// File: hw/rtl/sc2a_ctrl.sv
// Sequencing state machine for the scancode-to-ASCII key stack.
module sc2a_ctrl
    import sc2a_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  logic         m_ready,
    input  sc2a_status_t status,
    output sc2a_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_EXEC = 3'b010,
        ST_LOAD = 3'b100
    } sc2a_state_t;

    sc2a_state_t state_reg, state_next;
    logic        load_ok;

    // Output register is free when empty or being drained this cycle
    assign load_ok = (state_reg == ST_LOAD) && (!status.out_valid || m_ready);

    always_comb begin
        s_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: s_ready = 1'b1;
            ST_EXEC: s_ready = 1'b0;
            ST_LOAD: s_ready = load_ok;
            default: s_ready = 1'b0;
        endcase
    end

    assign cmd.capture = s_valid && s_ready;
    assign cmd.execute = (state_reg == ST_EXEC);
    assign cmd.load    = load_ok;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: state_next = ST_LOAD;
            ST_LOAD: begin
                if (load_ok) begin
                    state_next = s_valid ? ST_EXEC : ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    a_capture_to_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.capture |=> state_reg == ST_EXEC)
        else $error("accepted transaction did not start execution");

    a_exec_to_load: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_EXEC |=> state_reg == ST_LOAD)
        else $error("execution did not advance to result load");

endmodule

// File: hw/rtl/sc2a_dp.sv
// Datapath: item registers, shift and caps flags, character stack memory and result register.
module sc2a_dp
    import sc2a_pkg::*;
#(
    parameter int DEPTH = 256
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  sc2a_cmd_t    cmd,
    output sc2a_status_t status,
    input  logic [1:0]   s_action,
    input  logic [7:0]   s_scancode,
    input  logic         m_ready,
    output logic         m_valid,
    output logic [6:0]   m_read_char,
    output logic         m_pushed,
    output logic [7:0]   m_fill_count,
    output logic         m_shift_held,
    output logic         m_caps_on
);

    localparam int TOP_W  = $clog2(DEPTH);
    localparam int WIDE_W = (TOP_W > 8) ? TOP_W : 8;
    localparam logic [TOP_W-1:0] TOP_FULL = TOP_W'(DEPTH - 1);

    sc2a_action_t     action_reg;
    logic [7:0]       code_reg;
    logic             enabled_reg, enabled_next;
    logic             shift_reg, shift_next;
    logic             caps_reg, caps_next;
    logic [TOP_W-1:0] top_reg, top_next;
    logic             pushed_reg, pushed_next;
    logic             pop_hit_reg, pop_hit_next;
    logic [6:0]       rd_data_reg;
    logic             out_valid_reg;
    logic [6:0]       out_char_reg;
    logic             out_pushed_reg;
    logic [7:0]       out_fill_reg;
    logic             out_shift_reg;
    logic             out_caps_reg;

    logic [6:0]        stack_mem [DEPTH];
    logic [6:0]        plain_ch, mapped_ch;
    logic              wr_en;
    logic [TOP_W-1:0]  rd_addr;
    logic [WIDE_W-1:0] top_wide;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            action_reg <= sc2a_action_t'(s_action);
            code_reg   <= s_scancode;
        end
    end

    // Character lookup: shift wins over caps, caps only touches a..z
    always_comb begin
        plain_ch = plain_rom(code_reg[6:0]);
        if (shift_reg) begin
            mapped_ch = shifted_rom(code_reg[6:0]);
        end else if (caps_reg && plain_ch >= CHAR_LOWER_A && plain_ch <= CHAR_LOWER_Z) begin
            mapped_ch = plain_ch - CASE_OFFSET;
        end else begin
            mapped_ch = plain_ch;
        end
    end

    assign rd_addr = top_reg - TOP_W'(1);

    always_comb begin
        enabled_next = enabled_reg;
        shift_next   = shift_reg;
        caps_next    = caps_reg;
        top_next     = top_reg;
        pushed_next  = 1'b0;
        pop_hit_next = 1'b0;
        wr_en        = 1'b0;
        unique case (action_reg)
            ACT_SCAN: begin
                if (enabled_reg) begin
                    if (code_reg == SC_LSHIFT_MAKE || code_reg == SC_RSHIFT_MAKE) begin
                        shift_next = 1'b1;
                    end else if (code_reg == SC_LSHIFT_BREAK
                                 || code_reg == SC_RSHIFT_BREAK) begin
                        shift_next = 1'b0;
                    end else if (code_reg == SC_CAPS_MAKE) begin
                        caps_next = !caps_reg;
                    end else if ((code_reg & SC_BREAK_BIT) == 8'h00
                                 && mapped_ch != 7'h00 && top_reg != TOP_FULL) begin
                        wr_en       = 1'b1;
                        pushed_next = 1'b1;
                        top_next    = top_reg + TOP_W'(1);
                    end
                end
            end
            ACT_POP: begin
                if (top_reg != '0) begin
                    pop_hit_next = 1'b1;
                    top_next     = rd_addr;
                end
            end
            ACT_ACTIVATE: begin
                enabled_next = 1'b1;
                shift_next   = 1'b0;
                caps_next    = 1'b0;
                top_next     = '0;
            end
            ACT_DEACTIVATE: enabled_next = 1'b0;
            default: enabled_next = enabled_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enabled_reg <= 1'b0;
            shift_reg   <= 1'b0;
            caps_reg    <= 1'b0;
            top_reg     <= '0;
        end else if (cmd.execute) begin
            enabled_reg <= enabled_next;
            shift_reg   <= shift_next;
            caps_reg    <= caps_next;
            top_reg     <= top_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.execute) begin
            pushed_reg  <= pushed_next;
            pop_hit_reg <= pop_hit_next;
        end
    end

    // Stack memory: push writes at the top, pop reads just below it
    always_ff @(posedge aclk) begin
        if (cmd.execute && wr_en) begin
            stack_mem[top_reg] <= mapped_ch;
        end
        if (cmd.execute) begin
            rd_data_reg <= stack_mem[rd_addr];
        end
    end

    assign top_wide = WIDE_W'(top_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            out_char_reg   <= pop_hit_reg ? rd_data_reg : 7'h00;
            out_pushed_reg <= pushed_reg;
            out_fill_reg   <= top_wide[7:0];
            out_shift_reg  <= shift_reg;
            out_caps_reg   <= caps_reg;
        end
    end

    assign status.out_valid = out_valid_reg;
    assign m_valid      = out_valid_reg;
    assign m_read_char  = out_char_reg;
    assign m_pushed     = out_pushed_reg;
    assign m_fill_count = out_fill_reg;
    assign m_shift_held = out_shift_reg;
    assign m_caps_on    = out_caps_reg;

    a_top_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        top_reg <= TOP_FULL)
        else $error("stack top beyond capacity");

    a_push_advances: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.execute && wr_en |=> top_reg == $past(top_reg) + TOP_W'(1))
        else $error("push did not advance stack top");

endmodule

// File: hw/rtl/scancode_to_ascii_key_stack.sv
// Top level of the set-1 scancode to ASCII converter with a LIFO character stack.
// Each input transaction carries an action (scancode event, pop, activate, deactivate)
// and a scancode byte; each one returns exactly one result transaction with the popped
// character, a pushed flag, the stack fill count and the shift and caps-lock flags as
// they stand after that item. An item is first executed, which updates the flags and
// stack and issues the synchronous stack memory read, and then its result is loaded.
// The next item is accepted in the cycle its predecessor's result is loaded; a
// stalled result register holds the block until the result is taken. The stack
// memory has DEPTH entries and holds at most DEPTH-1 characters; it needs no
// clearing pass, since activate only resets the stack top and entries at or above
// the top are never read.
module scancode_to_ascii_key_stack
    import sc2a_pkg::*;
#(
    parameter int DEPTH = 256
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_action,
    input  logic [7:0] s_scancode,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [6:0] m_read_char,
    output logic       m_pushed,
    output logic [7:0] m_fill_count,
    output logic       m_shift_held,
    output logic       m_caps_on
);

    sc2a_cmd_t    cmd;
    sc2a_status_t status;

    // Controller: sequence capture, execute and result load per transaction
    sc2a_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Datapath: hold flags and stack, map scancodes, drive the result register
    sc2a_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .status       (status),
        .s_action     (s_action),
        .s_scancode   (s_scancode),
        .m_ready      (m_ready),
        .m_valid      (m_valid),
        .m_read_char  (m_read_char),
        .m_pushed     (m_pushed),
        .m_fill_count (m_fill_count),
        .m_shift_held (m_shift_held),
        .m_caps_on    (m_caps_on)
    );

endmodule

// File: test/scancode_to_ascii_key_stack_tb.sv
// Self-checking testbench for the scancode to ASCII key stack: directed and random traffic.
module scancode_to_ascii_key_stack_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sc2a_pkg::*;

    // Stack size under test; the block holds at most STACK_DEPTH-1 characters.
    localparam int STACK_DEPTH = 256;

    // Traffic shape
    localparam int RANDOM_ITEMS     = 1260;
    localparam int FILL_AT          = 250;   // random item index where the stack is filled
    localparam int FILL_KEYS        = 320;   // make codes sent in a row to overflow the stack
    localparam int PAUSE_AT         = 800;   // sender waits for all results here
    localparam int TX_STEADY_FIRST  = 500;   // sender offers back to back in this item range
    localparam int TX_STEADY_LAST   = 750;
    localparam int IDLE_PCT         = 38;

    // Result side: one long hold-off and one stretch that never stalls, in cycles after reset
    localparam int RX_HOLD_FROM     = 1200;
    localparam int RX_HOLD_CYCLES   = 400;
    localparam int RX_STEADY_FROM   = 3000;
    localparam int RX_STEADY_CYCLES = 1500;

    localparam int SETTLE_CYCLES    = 10;
    localparam int CYCLE_LIMIT      = 300000;

    // Keypad keys that sit outside the dense part of the key map
    localparam logic [7:0] KP_MINUS_MAKE  = 8'h4A;
    localparam logic [7:0] KP_PLUS_MAKE   = 8'h4E;
    localparam logic [7:0] LAST_DENSE_KEY = 8'h39;
    localparam logic [6:0] ASCII_MINUS    = 7'h2D;
    localparam logic [6:0] ASCII_PLUS     = 7'h2B;

    // Characters for make codes 0x00..0x39, unshifted and shifted
    localparam logic [6:0] PLAIN_KEYS [58] = '{
        7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
        7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
        7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
        7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73,
        7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
        7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
        7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
        7'h00, 7'h20
    };
    localparam logic [6:0] SHIFTED_KEYS [58] = '{
        7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
        7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
        7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
        7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00, 7'h41, 7'h53,
        7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
        7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
        7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A,
        7'h00, 7'h20
    };

    typedef struct packed {
        logic [6:0] read_char;
        logic       pushed;
        logic [7:0] fill_count;
        logic       shift_held;
        logic       caps_on;
    } key_report_t;

    // Tracks keyboard flags and the character stack, and queues the report each
    // accepted command should produce.
    class key_stack_board;
        logic [6:0]  char_stack [STACK_DEPTH];
        int unsigned stack_top;
        bit          shift_flag;
        bit          caps_flag;
        bit          enabled;
        key_report_t due_reports [$];
        int unsigned error_count;

        function void note_command(sc2a_action_t act, logic [7:0] code);
            key_report_t rep;
            logic [6:0]  ch;
            rep = '0;
            ch  = '0;
            case (act)
                ACT_SCAN: begin
                    if (!enabled) begin
                        // ignored while disabled
                    end else if (code == SC_LSHIFT_MAKE || code == SC_RSHIFT_MAKE) begin
                        shift_flag = 1'b1;
                    end else if (code == SC_LSHIFT_BREAK || code == SC_RSHIFT_BREAK) begin
                        shift_flag = 1'b0;
                    end else if (code == SC_CAPS_MAKE) begin
                        caps_flag = !caps_flag;
                    end else if ((code & SC_BREAK_BIT) == '0) begin
                        if (code <= LAST_DENSE_KEY) begin
                            ch = shift_flag ? SHIFTED_KEYS[code] : PLAIN_KEYS[code];
                        end else if (code == KP_MINUS_MAKE) begin
                            ch = ASCII_MINUS;
                        end else if (code == KP_PLUS_MAKE) begin
                            ch = ASCII_PLUS;
                        end
                        if (!shift_flag && caps_flag
                            && ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z) begin
                            ch = ch - CASE_OFFSET;
                        end
                        if (ch != '0 && stack_top < STACK_DEPTH - 1) begin
                            char_stack[stack_top] = ch;
                            stack_top++;
                            rep.pushed = 1'b1;
                        end
                    end
                end
                ACT_POP: begin
                    if (stack_top > 0) begin
                        stack_top--;
                        rep.read_char = char_stack[stack_top];
                    end
                end
                ACT_ACTIVATE: begin
                    enabled    = 1'b1;
                    shift_flag = 1'b0;
                    caps_flag  = 1'b0;
                    stack_top  = 0;
                end
                ACT_DEACTIVATE: begin
                    enabled = 1'b0;
                end
            endcase
            rep.fill_count = stack_top[7:0];
            rep.shift_held = shift_flag;
            rep.caps_on    = caps_flag;
            due_reports.push_back(rep);
        endfunction

        function void compare_field(string field, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
                error_count++;
            end
        endfunction

        function void check_report(key_report_t got);
            key_report_t want;
            if (due_reports.size() == 0) begin
                $error("result with no command outstanding: 0x%0h", got);
                error_count++;
                return;
            end
            want = due_reports.pop_front();
            compare_field("read_char", 8'(want.read_char), 8'(got.read_char));
            compare_field("pushed", 8'(want.pushed), 8'(got.pushed));
            compare_field("fill_count", want.fill_count, got.fill_count);
            compare_field("shift_held", 8'(want.shift_held), 8'(got.shift_held));
            compare_field("caps_on", 8'(want.caps_on), 8'(got.caps_on));
        endfunction
    endclass

    logic       aclk       = 1'b0;
    logic       aresetn    = 1'b0;
    logic       s_valid    = 1'b0;
    logic       s_ready;
    logic [1:0] s_action   = ACT_SCAN;
    logic [7:0] s_scancode = 8'h00;
    logic       m_valid;
    logic       m_ready    = 1'b0;
    logic [6:0] m_read_char;
    logic       m_pushed;
    logic [7:0] m_fill_count;
    logic       m_shift_held;
    logic       m_caps_on;

    key_stack_board board = new();
    bit sender_idles = 1'b1;

    scancode_to_ascii_key_stack #(
        .DEPTH(STACK_DEPTH)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_action     (s_action),
        .s_scancode   (s_scancode),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_read_char  (m_read_char),
        .m_pushed     (m_pushed),
        .m_fill_count (m_fill_count),
        .m_shift_held (m_shift_held),
        .m_caps_on    (m_caps_on)
    );

    always #5 aclk = ~aclk;

    // Watchdog: bail out if the run hangs on a handshake.
    always @(posedge aclk) begin : watchdog
        int unsigned cycles;
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Check every result transaction at the edge where it is taken.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            board.check_report({m_read_char, m_pushed, m_fill_count, m_shift_held, m_caps_on});
        end
    end

    // Result side: random stalls, one long hold-off so the block backs up into its
    // input, and one long stretch that takes every result at once.
    initial begin : result_sink
        int unsigned cyc;
        cyc = 0;
        @(posedge aresetn);
        forever begin
            @(posedge aclk);
            cyc++;
            if (cyc >= RX_HOLD_FROM && cyc < RX_HOLD_FROM + RX_HOLD_CYCLES) begin
                m_ready <= 1'b0;
            end else if (cyc >= RX_STEADY_FROM && cyc < RX_STEADY_FROM + RX_STEADY_CYCLES) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // Offer one transaction, idling first at random; return at the edge it is taken.
    task automatic send_command(input sc2a_action_t act, input logic [7:0] code);
        while (sender_idles && $urandom_range(0, 99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_action   <= act;
        s_scancode <= code;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.note_command(act, code);
    endtask

    // Drop valid and hold until every outstanding result has been taken.
    task automatic wait_for_results();
        s_valid <= 1'b0;
        while (board.due_reports.size() != 0) @(posedge aclk);
    endtask

    // Activate, then type far more keys than the stack holds so the tail is dropped.
    task automatic overflow_stack();
        send_command(ACT_ACTIVATE, 8'($urandom_range(0, 255)));
        repeat (FILL_KEYS) begin
            send_command(ACT_SCAN, 8'($urandom_range(1, LAST_DENSE_KEY)));
        end
    endtask

    // Mostly well-formed typing while enabled, with pops, mode changes and some noise.
    task automatic send_random_command(input int unsigned pop_pct);
        sc2a_action_t act;
        logic [7:0]   code;
        int unsigned  pick;
        int unsigned  key_pick;
        pick = $urandom_range(0, 99);
        code = 8'($urandom_range(0, 255));
        if (!board.enabled && pick < 20) begin
            act = ACT_ACTIVATE;
        end else if (pick < 3) begin
            act = sc2a_action_t'($urandom_range(0, 3));
        end else if (pick < 4) begin
            act = ACT_DEACTIVATE;
        end else if (pick < 5) begin
            act = ACT_ACTIVATE;
        end else if (pick < 5 + pop_pct) begin
            act = ACT_POP;
        end else begin
            act = ACT_SCAN;
            key_pick = $urandom_range(0, 99);
            if (key_pick < 6) begin
                code = $urandom_range(0, 1) ? SC_LSHIFT_MAKE : SC_RSHIFT_MAKE;
            end else if (key_pick < 12) begin
                code = $urandom_range(0, 1) ? SC_LSHIFT_BREAK : SC_RSHIFT_BREAK;
            end else if (key_pick < 15) begin
                code = SC_CAPS_MAKE;
            end else if (key_pick < 25) begin
                code = 8'($urandom_range(128, 255));
            end else begin
                code = 8'($urandom_range(0, 127));
            end
        end
        send_command(act, code);
    endtask

    initial begin : stimulus
        // Directed opening: disabled block, unmapped keys, caps and shift interplay,
        // the grave key both ways, break codes and the extended prefix, the keypad
        // keys, deactivate keeping the stack, and activate clearing it again.
        static sc2a_action_t opening_acts [25] = '{
            ACT_POP, ACT_SCAN, ACT_ACTIVATE, ACT_SCAN, ACT_SCAN,
            ACT_SCAN, ACT_SCAN, ACT_SCAN, ACT_SCAN, ACT_SCAN,
            ACT_SCAN, ACT_SCAN, ACT_SCAN, ACT_SCAN, ACT_SCAN,
            ACT_SCAN, ACT_SCAN, ACT_SCAN, ACT_SCAN, ACT_SCAN,
            ACT_DEACTIVATE, ACT_SCAN, ACT_POP, ACT_ACTIVATE, ACT_POP
        };
        static logic [7:0] opening_codes [25] = '{
            8'h00, 8'h1E, 8'h00, 8'h00, 8'h1E,
            SC_CAPS_MAKE, 8'h1E, SC_LSHIFT_MAKE, 8'h1E, 8'h29,
            SC_LSHIFT_BREAK, 8'h29, SC_RSHIFT_MAKE, SC_RSHIFT_BREAK, 8'hE0,
            8'hFF, 8'h9E, 8'h7F, KP_MINUS_MAKE, KP_PLUS_MAKE,
            8'hFF, 8'h10, 8'h00, 8'h00, 8'h00
        };
        int unsigned pop_pct;

        // Hold reset low, then release it at an edge.
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (opening_acts[i]) begin
            send_command(opening_acts[i], opening_codes[i]);
        end
        wait_for_results();

        pop_pct = 20;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // Shift the push/pop balance now and then so the stack both grows and drains.
            if (n % 64 == 0) pop_pct = $urandom_range(5, 55);
            sender_idles = !(n >= TX_STEADY_FIRST && n < TX_STEADY_LAST);
            if (n == FILL_AT) overflow_stack();
            if (n == PAUSE_AT) wait_for_results();
            send_random_command(pop_pct);
        end

        // Drain, then let the clock run on so that any stray result shows.
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (board.error_count == 0 && board.due_reports.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/sc2a_pkg.sv
hw/rtl/sc2a_ctrl.sv
hw/rtl/sc2a_dp.sv
hw/rtl/scancode_to_ascii_key_stack.sv
test/scancode_to_ascii_key_stack_tb.sv
